// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Whenever a holds on a clock edge, b must hold on the same edge.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Whenever a holds on a clock edge, b must hold on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== design/pslp_pkg.sv =====
package pslp_pkg;

    // Default pool size.
    localparam int NUM_SLOTS_DEF = 64;

    // Field widths.
    localparam int LIFE_W  = 16;
    localparam int RATE_W  = 16;
    localparam int DT_W    = 16;
    localparam int SIU_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 16;

    // Decrement is the Q8.24 product shifted down to Q1.15.
    localparam int PROD_W    = RATE_W + DT_W;
    localparam int DEC_SHIFT = 9;
    localparam int DEC_W     = PROD_W - DEC_SHIFT;

    // Lifetime of a freshly added particle: 1.0 in Q1.15.
    localparam logic [LIFE_W-1:0] LIFE_ONE = 16'h8000;

    // Register reset values.
    localparam logic [RATE_W-1:0] DECAY_RATE_RST   = 16'd256;
    localparam logic [SIU_W-1:0]  SLOTS_IN_USE_RST = 7'd64;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic {
        CFG_DECAY_RATE   = 1'b0,
        CFG_SLOTS_IN_USE = 1'b1
    } t_cfg_idx;

endpackage

// ===== design/pslp_ram.sv =====
module pslp_ram
    import pslp_pkg::*;
#(
    parameter int WIDTH = LIFE_W,
    parameter int DEPTH = NUM_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/particle_slot_pool_lifetime_top.sv =====
// Particle slot pool lifetime keeper with a next-fit slot allocator.
//
// Command channel: a word (i_operation, i_delta_time) is taken at a rising
// edge where start is high and busy is low. An add word finds a free slot,
// searching next-fit from the slot found last, and gives it lifetime 1.0;
// when every slot in use is live, slot 0 is reused and o_overwrote is set.
// A tick word ages every live slot by decay_rate times delta_time.
// Every command returns exactly one result word (o_slot, o_overwrote,
// o_live_count), shown for one cycle with o_valid high; the receiver
// cannot stall it, so no result is ever held back.
// Timing: each command makes one pass over the n slots in use through a
// single registered-read lifetime memory, one slot per cycle, as its read
// port allows. The block stays busy through S_MUL, S_SCAN, S_DRAIN and
// S_DONE, and registers the result on leaving S_DONE for S_IDLE.
// Configuration: i_cfg_valid/o_cfg_ready writes decay_rate (index 0) or
// slots_in_use (index 1); the port is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Reset loads the registers' reset values at once, then a clearing pass
// zeroes every memory slot with busy held high.
`include "assert_macros.svh"

module particle_slot_pool_lifetime_top
    import pslp_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel.
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [DT_W-1:0]    i_delta_time,
    // Result channel.
    output logic               o_valid,
    output logic [SLOT_W-1:0]  o_slot,
    output logic               o_overwrote,
    output logic [COUNT_W-1:0] o_live_count,
    // Configuration channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    // Slot index width, and a width wide enough to compare any slot count
    // against the pool size.
    localparam int IW   = $clog2(NUM_SLOTS);
    localparam int CMPW = (IW + 1 > SIU_W) ? IW + 1 : SIU_W;

    localparam logic [CMPW-1:0] NS_C      = CMPW'(NUM_SLOTS);
    localparam logic [IW-1:0]   LAST_SLOT = IW'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [RATE_W-1:0] r_decay_rate;
    logic [SIU_W-1:0]  r_slots_in_use;

    // Command context.
    t_op                r_op;
    logic [DT_W-1:0]    r_dt;
    logic [DEC_W-1:0]   r_dec;
    logic [SIU_W-1:0]   r_n;
    logic [IW-1:0]      r_last;
    logic [IW-1:0]      r_ss;

    // Scan pipeline: r_addr is the read address, r_pv/r_pidx tag the data
    // returning from the memory in the cycle after the read.
    logic [IW-1:0]      r_addr;
    logic               r_pv;
    logic [IW-1:0]      r_pidx;

    // Search and count results.
    logic               r_found_hi;
    logic               r_found_lo;
    logic [IW-1:0]      r_slot_hi;
    logic [IW-1:0]      r_slot_lo;
    logic [COUNT_W-1:0] r_count;

    // Result registers.
    logic               r_o_valid;
    logic [SLOT_W-1:0]  r_o_slot;
    logic               r_o_over;
    logic [COUNT_W-1:0] r_o_live;

    // Memory ports.
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [LIFE_W-1:0]  mem_wdata;
    logic [LIFE_W-1:0]  mem_rdata;

    // Combinational helpers.
    logic [CMPW-1:0]    siu_ext;
    logic [SIU_W-1:0]   n_active;
    logic [CMPW-1:0]    last_ext;
    logic [PROD_W-1:0]  product;
    logic [LIFE_W-1:0]  tick_new;
    logic               live_bit;
    logic               found;
    logic [IW-1:0]      fin_slot;
    logic [CMPW-1:0]    fin_slot_ext;

    pslp_ram #(
        .WIDTH (LIFE_W),
        .DEPTH (NUM_SLOTS)
    ) u_life_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    // Number of active slots: zero acts as one, and anything above the
    // pool size acts as the pool size.
    always_comb begin
        siu_ext = CMPW'(r_slots_in_use);
        if (r_slots_in_use == '0) begin
            n_active = SIU_W'(1);
        end else if (siu_ext > NS_C) begin
            n_active = SIU_W'(NUM_SLOTS);
        end else begin
            n_active = r_slots_in_use;
        end
        last_ext = CMPW'(n_active) - CMPW'(1);
    end

    assign product = PROD_W'(r_decay_rate) * PROD_W'(r_dt);

    // Shared aging unit: one compare and subtract per slot, saturating.
    always_comb begin
        if (r_dec >= DEC_W'(mem_rdata)) begin
            tick_new = '0;
        end else begin
            tick_new = mem_rdata - r_dec[LIFE_W-1:0];
        end
        if (r_op == OP_TICK) begin
            live_bit = (tick_new != '0);
        end else begin
            live_bit = (mem_rdata != '0);
        end
    end

    // Next-fit choice: the first free slot at or after the search start
    // wins, otherwise the first free slot below it, otherwise slot 0.
    always_comb begin
        found = r_found_hi | r_found_lo;
        if (r_found_hi) begin
            fin_slot = r_slot_hi;
        end else if (r_found_lo) begin
            fin_slot = r_slot_lo;
        end else begin
            fin_slot = '0;
        end
        fin_slot_ext = CMPW'(fin_slot);
    end

    // Write port: clearing pass, aged lifetimes during a tick, and the new
    // particle at the end of an add.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pidx;
        mem_wdata = tick_new;
        priority if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_addr;
            mem_wdata = '0;
        end else if (r_pv && (r_op == OP_TICK)) begin
            mem_we    = 1'b1;
            mem_waddr = r_pidx;
            mem_wdata = tick_new;
        end else if ((r_state == S_DONE) && (r_op == OP_ADD)) begin
            mem_we    = 1'b1;
            mem_waddr = fin_slot;
            mem_wdata = LIFE_ONE;
        end else begin
            mem_we    = 1'b0;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_rate   <= DECAY_RATE_RST;
            r_slots_in_use <= SLOTS_IN_USE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DECAY_RATE: begin
                    r_decay_rate <= i_cfg_data[RATE_W-1:0];
                end
                CFG_SLOTS_IN_USE: begin
                    r_slots_in_use <= i_cfg_data[SIU_W-1:0];
                end
                default: begin
                    r_decay_rate <= r_decay_rate;
                end
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_addr     <= '0;
            r_pv       <= 1'b0;
            r_ss       <= '0;
            r_o_valid  <= 1'b0;
            r_found_hi <= 1'b0;
            r_found_lo <= 1'b0;
            r_count    <= '0;
        end else begin
            r_o_valid <= 1'b0;
            r_pv      <= 1'b0;

            // Returning memory data: search for free slots and count.
            if (r_pv) begin
                if ((r_op == OP_ADD) && (mem_rdata == '0)) begin
                    if (r_pidx >= r_ss) begin
                        if (!r_found_hi) begin
                            r_found_hi <= 1'b1;
                            r_slot_hi  <= r_pidx;
                        end
                    end else if (!r_found_lo) begin
                        r_found_lo <= 1'b1;
                        r_slot_lo  <= r_pidx;
                    end
                end
                r_count <= r_count + COUNT_W'(live_bit);
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST_SLOT) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + IW'(1);
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_op       <= t_op'(i_operation);
                        r_dt       <= i_delta_time;
                        r_n        <= n_active;
                        r_last     <= last_ext[IW-1:0];
                        r_addr     <= '0;
                        r_found_hi <= 1'b0;
                        r_found_lo <= 1'b0;
                        r_count    <= '0;
                        r_state    <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_dec   <= product[PROD_W-1:DEC_SHIFT];
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_pv   <= 1'b1;
                    r_pidx <= r_addr;
                    if (r_addr == r_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + IW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_o_valid <= 1'b1;
                    if (r_op == OP_ADD) begin
                        r_o_slot <= fin_slot_ext[SLOT_W-1:0];
                        r_o_over <= !found;
                        r_o_live <= r_count + COUNT_W'(found);
                        if (found) begin
                            r_ss <= fin_slot;
                        end
                    end else begin
                        r_o_slot <= '0;
                        r_o_over <= 1'b0;
                        r_o_live <= r_count;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_o_valid;
    assign o_slot       = r_o_slot;
    assign o_overwrote  = r_o_over;
    assign o_live_count = r_o_live;

    // An accepted command always occupies the block on the next cycle.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // The scan never reads past the last active slot.
    `ASSERT_SAME(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_addr <= r_last)
    // Reusing slot 0 only happens when every active slot is live.
    `ASSERT_SAME(a_over_full, i_clk, i_rst_n, o_valid && o_overwrote, o_live_count == r_n)

endmodule
